[sv/dfe_pkg.sv]
// Package for the delimited field extractor: shared types, codes and defaults.
// No dependencies; used by every module of the block.
`default_nettype none

package dfe_pkg;

    // Default window depth in bytes
    localparam int PATTERN_MAX_BYTES_DEF = 8;

    // Widths fixed by the register and field formats
    localparam int PAT_W     = 64;
    localparam int LEN_REG_W = 4;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_PATTERN = 2'd0,
        CFG_HEAD_LENGTH  = 2'd1,
        CFG_TAIL_PATTERN = 2'd2,
        CFG_TAIL_LENGTH  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NO_HEAD = 2'd1,
        ST_NO_TAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_TAIL = 3'b010,
        PH_SKIP = 3'b100
    } t_phase;

    typedef struct packed {
        logic             is_done;
        logic [7:0]       content_byte;
        t_status          find_status;
        logic [CNT_W-1:0] content_length;
    } t_result;

endpackage

`default_nettype wire

[sv/dfe_window_match.sv]
// Delimiter compare of the byte window against one configured pattern.
// Depends on dfe_pkg.
`default_nettype none

module dfe_window_match #(
    parameter int PATTERN_MAX_BYTES = dfe_pkg::PATTERN_MAX_BYTES_DEF,
    localparam int LW = $clog2(PATTERN_MAX_BYTES + 1)
) (
    input  wire logic [PATTERN_MAX_BYTES-1:0][7:0] i_window, // [0] is newest
    input  wire logic [LW-1:0]                     i_fill,
    input  wire logic [dfe_pkg::PAT_W-1:0]         i_pattern,
    input  wire logic [LW-1:0]                     i_len,    // effective, 1..max
    output logic                                   o_match
);

    always_comb begin
        logic [dfe_pkg::PAT_W-1:0] v_sh;
        int                        v_k;
        o_match = (i_fill >= i_len);
        for (int j = 0; j < PATTERN_MAX_BYTES; j++) begin
            // oldest in-use byte meets pattern byte 0; bytes past the eighth are zero
            v_k  = int'(i_len) - 1 - j;
            v_sh = i_pattern >> (8 * v_k);
            if ((j < int'(i_len)) && (i_window[j] != v_sh[7:0])) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[sv/dfe_out_queue.sv]
// Three-entry result queue feeding the output stream; takes up to two results a cycle.
// Depends on dfe_pkg.
`default_nettype none

module dfe_out_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push_cnt,  // 0..2, only when o_room
    input  wire dfe_pkg::t_result i_res0,
    input  wire dfe_pkg::t_result i_res1,
    output logic                  o_room,      // two free places after this pop
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dfe_pkg::t_result      o_data
);

    dfe_pkg::t_result r_q [3];
    dfe_pkg::t_result n_q [3];
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             w_pop;
    logic [1:0]       w_base;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[0];
    assign w_pop   = o_valid && i_ready;
    assign w_base  = r_cnt - {1'b0, w_pop};
    assign o_room  = (w_base <= 2'd1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q[i] = (w_pop && i < 2) ? r_q[(i < 2) ? i + 1 : i] : r_q[i];
            if ((i_push_cnt != 2'd0) && (w_base == 2'(i))) begin
                n_q[i] = i_res0;
            end
            if ((i_push_cnt == 2'd2) && (w_base + 2'd1 == 2'(i))) begin
                n_q[i] = i_res1;
            end
        end
        n_cnt = w_base + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < 3; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

`default_nettype wire

[sv/delimited_field_extractor_core.sv]
// Top level of the delimited field extractor: input stage, search state, result queue.
// Depends on dfe_pkg, dfe_window_match and dfe_out_queue.
//
// Usage
//   Message bytes arrive on the s_axis channel, one byte per beat, tlast on
//   the final byte of a message. Results leave on m_axis: tuser=0 beats carry
//   tentative content bytes, a tuser=1 beat carries the status and length and
//   ends the run. On a failure status the receiver drops that run's bytes.
//   Registers are written through the cfg channel (always ready) while idle.
// Throughput and flow
//   One byte per cycle, back to back, while the result queue has room. A byte is
//   registered at accept and its results go from that register into the queue,
//   which drives m_axis. A byte with both a content beat and the status beat
//   sends them as consecutive beats; with a ready receiver nothing stalls.
// Stalls and reset
//   A three-entry result queue sits before m_axis; the input stage only
//   processes a byte when two places are free after this cycle's pop, so a
//   stalled receiver holds s_axis_tready low once two beats wait there.
//   Nothing is lost. Reset (synchronous, active low) empties the queue, returns
//   the search to the head phase and loads the register defaults (lengths 1).
`default_nettype none

module delimited_field_extractor_core #(
    parameter int PATTERN_MAX_BYTES = dfe_pkg::PATTERN_MAX_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input byte stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] message_byte
    input  wire logic                          s_axis_tlast,  // final_byte
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // [7:0] content_byte,
                                                              // [9:8] find_status,
                                                              // [25:10] content_length
    output logic                               m_axis_tuser,  // is_done
    // register writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dfe_pkg::PAT_W-1:0]     i_cfg_data
);

    localparam int P  = PATTERN_MAX_BYTES;
    localparam int LW = $clog2(P + 1);
    localparam int IW = (P > 1) ? $clog2(P) : 1;
    localparam logic [dfe_pkg::CNT_W-1:0] CNT_MAX = '1;

    // ---------------- configuration registers ----------------
    logic [dfe_pkg::PAT_W-1:0]     r_head_pat;
    logic [dfe_pkg::LEN_REG_W-1:0] r_head_size;
    logic [dfe_pkg::PAT_W-1:0]     r_tail_pat;
    logic [dfe_pkg::LEN_REG_W-1:0] r_tail_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_pat  <= '0;
            r_head_size <= dfe_pkg::LEN_REG_W'(1);
            r_tail_pat  <= '0;
            r_tail_size <= dfe_pkg::LEN_REG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (dfe_pkg::t_cfg_index'(i_cfg_index))
                dfe_pkg::CFG_HEAD_PATTERN: r_head_pat  <= i_cfg_data;
                dfe_pkg::CFG_HEAD_LENGTH:  r_head_size <= i_cfg_data[dfe_pkg::LEN_REG_W-1:0];
                dfe_pkg::CFG_TAIL_PATTERN: r_tail_pat  <= i_cfg_data;
                dfe_pkg::CFG_TAIL_LENGTH:  r_tail_size <= i_cfg_data[dfe_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective lengths: zero acts as one, anything above the depth as the depth
    function automatic logic [LW-1:0] eff_len(input logic [dfe_pkg::LEN_REG_W-1:0] v);
        logic [LW-1:0] l;
        if (v == '0) begin
            l = LW'(1);
        end else if (int'(v) > P) begin
            l = LW'(P);
        end else begin
            l = LW'(v);
        end
        return l;
    endfunction

    logic [LW-1:0] w_hl;
    logic [LW-1:0] w_tl;
    logic [IW-1:0] w_tl_idx;

    assign w_hl     = eff_len(r_head_size);
    assign w_tl     = eff_len(r_tail_size);
    assign w_tl_idx = IW'(w_tl - LW'(1));

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fin;
    logic       w_room;
    logic       w_fire;

    assign w_fire        = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_fin  <= s_axis_tlast;
        end
    end

    // ---------------- search state ----------------
    dfe_pkg::t_phase         r_phase, n_phase;
    logic [P-1:0][7:0]       r_win, n_win;   // [0] newest; payload, no reset
    logic [LW-1:0]           r_fill, n_fill; // bytes seen in this phase, saturating
    logic [dfe_pkg::CNT_W-1:0] r_len, n_len;

    logic [P-1:0][7:0] w_win_sh;
    logic [LW-1:0]     w_fill_inc;
    logic              w_head_hit;
    logic              w_tail_hit;

    always_comb begin
        w_win_sh[0] = r_in_byte;
        for (int i = 1; i < P; i++) begin
            w_win_sh[i] = r_win[i-1];
        end
    end

    assign w_fill_inc = (r_fill == LW'(P)) ? r_fill : r_fill + LW'(1);

    // Both compares look at the window with the current byte already in
    dfe_window_match #(.PATTERN_MAX_BYTES(P)) u_head_match (
        .i_window  (w_win_sh),
        .i_fill    (w_fill_inc),
        .i_pattern (r_head_pat),
        .i_len     (w_hl),
        .o_match   (w_head_hit)
    );

    dfe_window_match #(.PATTERN_MAX_BYTES(P)) u_tail_match (
        .i_window  (w_win_sh),
        .i_fill    (w_fill_inc),
        .i_pattern (r_tail_pat),
        .i_len     (w_tl),
        .o_match   (w_tail_hit)
    );

    // ---------------- per-byte step ----------------
    dfe_pkg::t_result w_res0;
    dfe_pkg::t_result w_res1;
    logic [1:0]       w_nres;

    always_comb begin
        dfe_pkg::t_result          v_r;
        logic [dfe_pkg::CNT_W-1:0] v_len;
        n_phase = r_phase;
        n_win   = r_win;
        n_fill  = r_fill;
        n_len   = r_len;
        w_res0  = '0;
        w_res1  = '0;
        w_nres  = 2'd0;
        v_r     = '0;
        v_len   = r_len;

        unique case (r_phase)
            dfe_pkg::PH_HEAD: begin
                n_win  = w_win_sh;
                n_fill = w_fill_inc;
                if (w_head_hit) begin
                    n_phase = dfe_pkg::PH_TAIL;
                    n_fill  = '0;
                    n_len   = '0;
                    if (r_in_fin) begin
                        // head ends on the last byte: no room left for a tail
                        w_res0             = '0;
                        w_res0.is_done     = 1'b1;
                        w_res0.find_status = dfe_pkg::ST_NO_TAIL;
                        w_nres             = 2'd1;
                    end
                end else if (r_in_fin) begin
                    w_res0             = '0;
                    w_res0.is_done     = 1'b1;
                    w_res0.find_status = dfe_pkg::ST_NO_HEAD;
                    w_nres             = 2'd1;
                end
            end
            dfe_pkg::PH_TAIL: begin
                // content is held back by the tail length, so tail bytes never leave
                if (r_fill >= w_tl) begin
                    w_res0              = '0;
                    w_res0.content_byte = r_win[w_tl_idx];
                    w_nres              = 2'd1;
                    if (r_len != CNT_MAX) begin
                        v_len = r_len + dfe_pkg::CNT_W'(1);
                    end
                end
                n_len  = v_len;
                n_win  = w_win_sh;
                n_fill = w_fill_inc;
                v_r    = '0;
                v_r.is_done = 1'b1;
                if (w_tail_hit) begin
                    v_r.find_status    = dfe_pkg::ST_FOUND;
                    v_r.content_length = v_len;
                    n_phase            = dfe_pkg::PH_SKIP;
                end else begin
                    v_r.find_status    = dfe_pkg::ST_NO_TAIL;
                end
                if (w_tail_hit || r_in_fin) begin
                    if (w_nres == 2'd0) begin
                        w_res0 = v_r;
                    end else begin
                        w_res1 = v_r;
                    end
                    w_nres = w_nres + 2'd1;
                end
            end
            dfe_pkg::PH_SKIP: begin
                // bytes after the tail: nothing until the end of the message
            end
            default: begin
                n_phase = dfe_pkg::PH_HEAD;
            end
        endcase

        if (r_in_fin) begin
            n_phase = dfe_pkg::PH_HEAD;
            n_fill  = '0;
            n_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dfe_pkg::PH_HEAD;
            r_fill  <= '0;
            r_len   <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
        end
        if (w_fire) begin
            r_win <= n_win;
        end
    end

    // ---------------- result queue and output packing ----------------
    dfe_pkg::t_result w_out;

    dfe_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_fire ? w_nres : 2'd0),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_room     (w_room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (w_out)
    );

    assign m_axis_tuser = w_out.is_done;
    assign m_axis_tdata = {6'd0, w_out.content_length, w_out.find_status, w_out.content_byte};

endmodule

`default_nettype wire

[sim/dfe_result_checker.sv]
// Result checker for the delimited field extractor: watches the byte, result and
// register channels, predicts every result beat and compares it field by field.
// Depends on dfe_pkg for the register indexes, status codes, phases and result layout.
module dfe_result_checker
    import dfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [31:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_beats,
    output int                   o_found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = PATTERN_MAX_BYTES_DEF;

    logic [PAT_W-1:0]     head_pat, tail_pat;
    logic [LEN_REG_W-1:0] head_size, tail_size;

    t_phase           phase;
    logic [7:0]       window [WIN];   // index 0 is the newest byte
    int unsigned      fill;
    logic [CNT_W-1:0] run_len;

    t_result due_results [$];
    int      fails, beats, founds;

    function automatic int unsigned in_use(input logic [LEN_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > WIN) return WIN;
        return v;
    endfunction

    function void clear_run();
        phase = PH_HEAD;
        foreach (window[i]) window[i] = 8'h00;
        fill    = 0;
        run_len = '0;
    endfunction

    function void expect_beat(input logic done, input logic [7:0] b, input t_status st,
                              input logic [CNT_W-1:0] n);
        t_result r;
        r.is_done        = done;
        r.content_byte   = b;
        r.find_status    = st;
        r.content_length = n;
        due_results.push_back(r);
    endfunction

    function void shift_window(input logic [7:0] b);
        for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (fill < WIN) fill++;
    endfunction

    function bit window_holds(input logic [PAT_W-1:0] pat, input int unsigned n);
        if (fill < n) return 1'b0;
        for (int unsigned k = 0; k < n; k++)
            if (window[n-1-k] != pat[8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    // One accepted message byte: advance the search and queue what it yields.
    // Content bytes trail by the tail length so tail bytes never come out.
    function void extract_step(input logic [7:0] b, input logic fin);
        int unsigned tl;
        tl = in_use(tail_size);
        if (phase == PH_HEAD) begin
            shift_window(b);
            if (window_holds(head_pat, in_use(head_size))) begin
                phase   = PH_TAIL;
                fill    = 0;
                run_len = '0;
                if (fin) expect_beat(1'b1, 8'h00, ST_NO_TAIL, '0);
            end else if (fin) begin
                expect_beat(1'b1, 8'h00, ST_NO_HEAD, '0);
            end
        end else if (phase == PH_TAIL) begin
            if (fill >= tl) begin
                expect_beat(1'b0, window[tl-1], ST_FOUND, '0);
                if (run_len != '1) run_len++;
            end
            shift_window(b);
            if (window_holds(tail_pat, tl)) begin
                expect_beat(1'b1, 8'h00, ST_FOUND, run_len);
                phase = PH_SKIP;
            end else if (fin) begin
                expect_beat(1'b1, 8'h00, ST_NO_TAIL, '0);
            end
        end
        if (fin) clear_run();
    endfunction

    function void report_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        fails++;
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
    endfunction

    function void check_beat();
        t_result r;
        if (due_results.size() == 0) begin
            fails++;
            $error("result beat with nothing pending: tdata %h tuser %b",
                   m_axis_tdata, m_axis_tuser);
            return;
        end
        r = due_results.pop_front();
        beats++;
        if (m_axis_tuser != r.is_done)
            report_field("is_done", r.is_done, m_axis_tuser);
        if (m_axis_tdata[7:0] != r.content_byte)
            report_field("content_byte", r.content_byte, m_axis_tdata[7:0]);
        if (m_axis_tdata[9:8] != r.find_status)
            report_field("find_status", r.find_status, m_axis_tdata[9:8]);
        if (m_axis_tdata[25:10] != r.content_length)
            report_field("content_length", r.content_length, m_axis_tdata[25:10]);
        if (r.is_done && r.find_status == ST_FOUND) founds++;
    endfunction

    // Reads happen in the active region of the edge, so all values are pre-edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_pat  = '0;
            head_size = 4'd1;
            tail_pat  = '0;
            tail_size = 4'd1;
            clear_run();
            due_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_beat();
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_HEAD_PATTERN: head_pat  = i_cfg_data;
                    CFG_HEAD_LENGTH:  head_size = i_cfg_data[LEN_REG_W-1:0];
                    CFG_TAIL_PATTERN: tail_pat  = i_cfg_data;
                    CFG_TAIL_LENGTH:  tail_size = i_cfg_data[LEN_REG_W-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) extract_step(s_axis_tdata, s_axis_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
        o_beats      <= beats;
        o_found      <= founds;
    end

endmodule

[sim/tb_delimited_field_extractor_core.sv]
// Testbench top for delimited_field_extractor_core: clock, reset, register set-up,
// byte stimulus with random idling and long receiver stalls, and the verdict.
// Depends on dfe_pkg, the block itself and dfe_result_checker.
module tb_delimited_field_extractor_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dfe_pkg::*;

    localparam int RAND_ITEMS  = 1000;   // counted bytes in the random part
    localparam int N_SETTINGS  = 16;     // one register setting per random phase
    localparam int HOLD_CYCLES = 150;    // long receiver stall
    localparam int SETTLE      = 4;      // drain margin after the queue empties
    localparam int DRAIN_LIMIT = 5000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [7:0]           s_axis_tdata  = 8'h00;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_HEAD_PATTERN;
    logic [PAT_W-1:0]     i_cfg_data    = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        o_cfg_ready;

    int fail_cnt, pending, beats, found_cnt;

    // Stimulus-side copy of the registers, only used to shape messages
    logic [PAT_W-1:0]     head_pat  = '0;
    logic [PAT_W-1:0]     tail_pat  = '0;
    logic [LEN_REG_W-1:0] head_size = 4'd1;
    logic [LEN_REG_W-1:0] tail_size = 4'd1;

    logic [8:0] msg_q [$];        // {last, byte} per beat of the next message
    int         msg_cnt, byte_cnt;

    delimited_field_extractor_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dfe_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_cnt),
        .o_pending     (pending),
        .o_beats       (beats),
        .o_found       (found_cnt)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop, well beyond the slowest legal run
    initial begin
        #5ms;
        $display("** delimited_field_extractor_core: FAILED **");
        $finish;
    end

    // Receiver: random stall per beat, plus two long stalls early in the random part
    // so the three-entry result queue fills and s_axis_tready drops.
    initial begin
        int hold;
        int seen;
        seen = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = $urandom_range(0, 9);
            if (seen == 40 || seen == 400) hold += HOLD_CYCLES;
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            seen++;
            @(negedge i_clk);
        end
    end

    function automatic int unsigned in_use(input logic [LEN_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > PATTERN_MAX_BYTES_DEF) return PATTERN_MAX_BYTES_DEF;
        return v;
    endfunction

    // Mostly random, sometimes a delimiter byte, to provoke partial matches
    function automatic logic [7:0] pick(input logic [PAT_W-1:0] pat, input int unsigned n);
        int unsigned k;
        k = $urandom_range(0, n - 1);
        if ($urandom_range(0, 3) == 0) return pat[8*k +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // Entered and left at a falling edge; tvalid only drops when a gap is drawn.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        byte_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i]) send_beat(msg_q[i][7:0], msg_q[i][8]);
        msg_cnt++;
    endtask

    // Leaves valid high; the caller lowers it after the last register.
    task automatic cfg_write(input t_cfg_index idx, input logic [PAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Length writes carry random upper bits, which the block must drop.
    task automatic cfg_apply(input logic [PAT_W-1:0] hp, input logic [LEN_REG_W-1:0] hl,
                             input logic [PAT_W-1:0] tp, input logic [LEN_REG_W-1:0] tl);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(CFG_HEAD_PATTERN, hp);
        cfg_write(CFG_HEAD_LENGTH, {junk[63:4], hl});
        cfg_write(CFG_TAIL_PATTERN, tp);
        cfg_write(CFG_TAIL_LENGTH, {junk[59:0], tl});
        i_cfg_valid <= 1'b0;
        head_pat  = hp;
        head_size = hl;
        tail_pat  = tp;
        tail_size = tl;
    endtask

    // Quiet the input, let every pending result drain, then allow for bytes
    // still in flight that yield nothing.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Message shapes: well-formed (60%), tail missing, head on the last byte,
    // broken head with a tail, and plain noise. Bytes after the tail are not
    // counted since the block ignores them.
    task automatic build_message(output int counted);
        int unsigned hn, tn, kind, pre, body, post, k;
        bit          full_head, with_body, with_tail;
        logic [8:0]  last_b;
        msg_q.delete();
        hn        = in_use(head_size);
        tn        = in_use(tail_size);
        kind      = $urandom_range(0, 99);
        pre       = $urandom_range(0, 5);
        body      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        post      = $urandom_range(0, 3);
        full_head = kind < 75;
        with_body = kind < 70 || kind >= 75;
        with_tail = kind < 60 || (kind >= 75 && kind < 80);
        if (kind >= 80) begin
            repeat ($urandom_range(1, 10)) msg_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else begin
            repeat (pre) msg_q.push_back({1'b0, pick(head_pat, hn)});
            for (k = 0; k < (full_head ? hn : hn - 1); k++)
                msg_q.push_back({1'b0, head_pat[8*k +: 8]});
            if (with_body)
                repeat (body) msg_q.push_back({1'b0, pick(tail_pat, tn)});
            if (with_tail)
                for (k = 0; k < tn; k++) msg_q.push_back({1'b0, tail_pat[8*k +: 8]});
        end
        counted = msg_q.size();
        if (with_tail)
            repeat (post) msg_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        last_b    = msg_q.pop_back();
        last_b[8] = 1'b1;
        msg_q.push_back(last_b);
    endtask

    initial begin
        int          got, ph_items;
        int          waited;
        logic [63:0] hp, tp;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: one-byte head of 0x00, so a lone zero ends on the head
        send_beat(8'h00, 1'b1);
        settle();

        // Head "AB", tail "YZ"
        cfg_apply(64'h4241, 4'd2, 64'h5A59, 4'd2);
        // Found with extreme content bytes, then bytes after the tail
        msg_q = '{9'h041, 9'h042, 9'h000, 9'h0FF, 9'h059, 9'h05A, 9'h055, 9'h111};
        send_message();
        // Tail missing at the end
        msg_q = '{9'h041, 9'h042, 9'h080, 9'h17F};
        send_message();
        // No head at all
        msg_q = '{9'h041, 9'h143};
        send_message();
        // Empty field, tail on the last byte
        msg_q = '{9'h041, 9'h042, 9'h059, 9'h15A};
        send_message();
        // Head finishing on the last byte
        msg_q = '{9'h041, 9'h142};
        send_message();

        // Random part: lengths sweep 0..15 on both registers, all-zero and
        // all-one patterns at the two ends.
        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            settle();
            hp = (ph == 0) ? 64'd0 : (ph == N_SETTINGS - 1) ? '1 : {$urandom, $urandom};
            tp = (ph == 0) ? '1 : (ph == N_SETTINGS - 1) ? 64'd0 : {$urandom, $urandom};
            cfg_apply(hp, 4'(ph), tp, 4'(N_SETTINGS - 1 - ph));
            ph_items = 0;
            while (ph_items < RAND_ITEMS / N_SETTINGS) begin
                build_message(got);
                send_message();
                ph_items += got;
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (pending != 0) $error("%0d expected result beats never arrived", pending);

        $display("Run covered %0d messages over %0d bytes, %0d result beats, %0d found runs;",
                 msg_cnt, byte_cnt, beats, found_cnt);
        $display("lengths 0..15 on both delimiters, random idling and long output stalls.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("** delimited_field_extractor_core: PASSED **");
        end else begin
            $display("** delimited_field_extractor_core: FAILED **");
        end
        $finish;
    end

endmodule
